// ===== hdl/pli_pkg.sv =====
package pli_pkg;

    // Fraction width and the value that stands for one whole segment.
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

    // Remainder and divisor widths of the fraction divider.
    localparam int DEN_W = 33;
    localparam int REM_W = 34;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic              valid;
        logic              den_zero;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [FRAC_W-1:0] quot;
    } div_cell_t;

endpackage

// ===== hdl/pli_div_cell.sv =====
module pli_div_cell
    import pli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_cell_t cell_in,
    output div_cell_t cell_out
);

    logic              ge;
    logic [REM_W-1:0]  rem_sub;
    logic              valid_reg;
    logic              den_zero_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [FRAC_W-1:0] quot_reg;

    // One restoring step: compare, subtract, shift in one quotient bit.
    assign ge      = cell_in.rem >= {1'b0, cell_in.den};
    assign rem_sub = ge ? (cell_in.rem - {1'b0, cell_in.den}) : cell_in.rem;

    // The valid flag is control state; the payload follows it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_zero_reg <= cell_in.den_zero;
        den_reg      <= cell_in.den;
        rem_reg      <= {rem_sub[REM_W-2:0], 1'b0};
        quot_reg     <= {cell_in.quot[FRAC_W-2:0], ge};
    end

    assign cell_out = '{valid: valid_reg, den_zero: den_zero_reg, rem: rem_reg,
                        den: den_reg, quot: quot_reg};

endmodule

// ===== hdl/polyline_segment_interpolate_top.sv =====
// Piecewise linear lookup over a table of up to MAX_POINTS (x, y) breakpoints in
// signed Q16.16. A write transaction (tuser 0) stores one point. A query
// transaction (tuser 1) passes through the span check, a scan that visits one
// segment at a time through the point memory's single read port, the launch of
// the divider and the chain of fraction divider cells; the multiply is then
// registered with the fraction, and the result goes into the result register.
// New transactions are taken only once the result is registered. Outside the
// span the result is all zeros and skips the scan and the divider. A result that
// waits for m_tready holds off further input.
module polyline_segment_interpolate_top
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [8:0]   cfg_wdata,      // point_count
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,        // point_index, point_x, point_y, query_x
    input  logic         s_tuser,        // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata         // inside_res, found, segment_index, start_x,
                                         // start_y, end_x, end_y, fraction, hit_y, pad
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NCELL = FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE, S_X0, S_XN, S_SCAN, S_LAUNCH, S_WAIT, S_FIN
    } state_t;

    state_t state_reg;

    logic [8:0]  count_reg;
    logic [AW-1:0] nm1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] idx_reg;
    logic [31:0] xmem [MAX_POINTS];
    logic [31:0] ymem [MAX_POINTS];
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [31:0] q_reg, sx_reg, sy_reg, ex_reg, ey_reg;
    logic        found_reg, inside_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic signed [50:0] prod_reg;
    logic        m_tvalid_reg;
    logic [191:0] m_tdata_reg;

    logic        in_acc, wr_acc;
    logic signed [31:0] lo, hi;
    logic        in_seg;
    logic signed [32:0] dnum, dden, dy;
    logic [DEN_W-1:0] anum, aden;
    logic signed [50:0] hy_sum;
    logic signed [31:0] hy;
    logic [FRAC_W-1:0] frac_res;

    div_cell_t chain [NCELL+1];

    assign in_acc = s_tvalid && s_tready;
    assign wr_acc = in_acc && !s_tuser;
    assign s_tready = (state_reg == S_IDLE);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    // Index of the last point in use, after clamping the count.
    always_comb
    begin
        if (count_reg == 9'd0)
        begin
            nm1 = '0;
        end
        else if (32'(count_reg) > 32'(MAX_POINTS))
        begin
            nm1 = AW'(MAX_POINTS - 1);
        end
        else
        begin
            nm1 = AW'(count_reg - 9'd1);
        end
    end

    // Read address for the next cycle's memory data.
    always_comb
    begin
        case (state_reg)
            S_X0:    rd_addr = nm1;
            S_XN:    rd_addr = AW'(1);
            S_SCAN:  rd_addr = idx_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    // Point memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_acc && (32'(s_tdata[7:0]) < 32'(MAX_POINTS)))
        begin
            xmem[AW'(s_tdata[7:0])] <= s_tdata[39:8];
            ymem[AW'(s_tdata[7:0])] <= s_tdata[71:40];
        end
        rx_reg <= xmem[rd_addr];
        ry_reg <= ymem[rd_addr];
    end

    // Interval test of the query against the current segment or the span.
    always_comb
    begin
        lo = (sx_reg < rx_reg) ? sx_reg : rx_reg;
        hi = (sx_reg < rx_reg) ? rx_reg : sx_reg;
    end
    assign in_seg = (q_reg >= lo) && (q_reg <= hi);

    // Divider operands are the absolute distances along x.
    assign dnum = 33'(q_reg) - 33'(sx_reg);
    assign dden = 33'(ex_reg) - 33'(sx_reg);
    assign anum = dnum[32] ? DEN_W'(-dnum) : DEN_W'(dnum);
    assign aden = dden[32] ? DEN_W'(-dden) : DEN_W'(dden);
    assign dy   = 33'(ey_reg) - 33'(sy_reg);

    // Head of the divider chain.
    always_comb
    begin
        chain[0].valid    = (state_reg == S_LAUNCH);
        chain[0].den_zero = (aden == '0);
        chain[0].rem      = {1'b0, anum};
        chain[0].den      = aden;
        chain[0].quot     = '0;
    end

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        pli_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    assign frac_res = chain[NCELL].den_zero ? '0 : chain[NCELL].quot;

    // Rounded interpolation: sy + floor(dy * frac / 2^16 + 1/2), frac in units of 2^-16.
    assign hy_sum = (prod_reg + 51'sd32768) >>> 16;
    assign hy     = sy_reg + hy_sum[31:0];

    // Query sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != S_FIN))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && s_tuser)
                    begin
                        q_reg     <= s_tdata[103:72];
                        found_reg <= 1'b0;
                        state_reg <= S_X0;
                    end
                end
                S_X0:
                begin
                    sx_reg    <= rx_reg;
                    sy_reg    <= ry_reg;
                    state_reg <= S_XN;
                end
                S_XN:
                begin
                    inside_reg <= in_seg;
                    idx_reg    <= AW'(1);
                    ex_reg     <= sx_reg;
                    ey_reg     <= sy_reg;
                    if (!in_seg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (nm1 == '0)
                    begin
                        state_reg <= S_LAUNCH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    ex_reg <= rx_reg;
                    ey_reg <= ry_reg;
                    if (in_seg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_LAUNCH;
                    end
                    else
                    begin
                        sx_reg <= rx_reg;
                        sy_reg <= ry_reg;
                        if (idx_reg == nm1)
                        begin
                            state_reg <= S_LAUNCH;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + AW'(1);
                        end
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (chain[NCELL].valid)
                    begin
                        frac_reg  <= frac_res;
                        prod_reg  <= 51'(dy) * 51'($signed({1'b0, frac_res}));
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (inside_reg)
                        begin
                            m_tdata_reg <= {5'd0, hy, frac_reg, ey_reg, ex_reg, sy_reg,
                                            sx_reg,
                                            found_reg ? 8'(idx_reg) : 8'd0,
                                            found_reg, 1'b1};
                        end
                        else
                        begin
                            m_tdata_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic [NCELL-1:0] cell_valid;
    for (genvar v = 0; v < NCELL; v++)
    begin : g_vld
        assign cell_valid[v] = chain[v+1].valid;
    end

    // At most one query is in the divider chain.
    a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_valid))
        else $error("more than one query in the divider chain");

    // The chain is empty whenever new transactions are taken.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cell_valid == '0))
        else $error("divider busy while idle");

    // A delivered fraction never passes the segment end.
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[154:138] <= FRAC_ONE))
        else $error("fraction out of range");

endmodule
